[rtl/core/tlkj_pkg.sv]
// ----------------------------------------------------------------------------
// tlkj_pkg
// Types, constants and helpers shared by the two-link kinematics datapath.
// ----------------------------------------------------------------------------
package tlkj_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int FRAC_BITS     = 12;
    localparam int CORDIC_STEPS  = 24;
    localparam int UNIT_SHIFT    = 30;
    localparam int UNIT_W        = 33;
    localparam int ZW            = 32;
    localparam int TERM_W        = 19;
    localparam int IN_DATA_W     = 64;
    localparam int OUT_DATA_W    = 184;
    localparam int CFG_ADDR_W    = 8;
    localparam int LEN_W         = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_LEN_ONE = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LEN_TWO = 8'd1;
    localparam logic [LEN_W-1:0]      LEN_RESET   = 16'd4096;

    localparam logic signed [UNIT_W-1:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic signed [ZW-1:0] ARC_TABLE [CORDIC_STEPS] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    typedef struct packed {
        logic signed [UNIT_W-1:0] co;
        logic signed [UNIT_W-1:0] si;
    } t_unit;

    typedef struct packed {
        logic [LEN_W-1:0] len_one;
        logic [LEN_W-1:0] len_two;
    } t_link_cfg;

    typedef struct packed {
        logic [ANGLE_BITS-1:0]  phi;
        logic signed [15:0]     rate_one;
        logic signed [15:0]     rate_two;
        logic signed [16:0]     vel_w;
    } t_side;

    typedef struct packed {
        logic signed [16:0] vel_w;
        logic signed [21:0] vel_y;
        logic signed [21:0] vel_x;
        logic signed [16:0] jac_yq2;
        logic signed [17:0] jac_yq1;
        logic signed [16:0] jac_xq2;
        logic signed [17:0] jac_xq1;
        logic [15:0]        pose_phi;
        logic signed [17:0] pose_y;
        logic signed [17:0] pose_x;
    } t_result;

    function automatic logic signed [17:0] sat18(input logic signed [19:0] v);
        if (v > 20'sd131071) begin
            return 18'sd131071;
        end else if (v < -20'sd131072) begin
            return -18'sd131072;
        end
        return v[17:0];
    endfunction

    function automatic logic signed [16:0] sat17(input logic signed [19:0] v);
        if (v > 20'sd65535) begin
            return 17'sd65535;
        end else if (v < -20'sd65536) begin
            return -17'sd65536;
        end
        return v[16:0];
    endfunction

    function automatic logic signed [21:0] sat22(input logic signed [34:0] v);
        if (v > 35'sd2097151) begin
            return 22'sd2097151;
        end else if (v < -35'sd2097152) begin
            return -22'sd2097152;
        end
        return v[21:0];
    endfunction

endpackage

[rtl/core/tlkj_cordic_lane.sv]
// ----------------------------------------------------------------------------
// tlkj_cordic_lane
// Pipelined rotation CORDIC: turn angle to Q3.30 cosine and sine.
// ----------------------------------------------------------------------------
module tlkj_cordic_lane
    import tlkj_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ANGLE_BITS-1:0] i_angle,
    output t_unit                 o_unit
);

    logic signed [UNIT_W-1:0] r_x [CORDIC_STEPS];
    logic signed [UNIT_W-1:0] r_y [CORDIC_STEPS];
    logic signed [ZW-1:0]     r_z [CORDIC_STEPS];
    logic [1:0]               r_q [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
        logic signed [UNIT_W-1:0] x_in;
        logic signed [UNIT_W-1:0] y_in;
        logic signed [ZW-1:0]     z_in;
        logic [1:0]               q_in;

        if (i == 0) begin : g_first
            assign x_in = CORDIC_GAIN;
            assign y_in = '0;
            assign z_in = $signed({2'b00, i_angle[ANGLE_BITS-3:0],
                                   {(ZW-ANGLE_BITS){1'b0}}});
            assign q_in = i_angle[ANGLE_BITS-1:ANGLE_BITS-2];
        end else begin : g_next
            assign x_in = r_x[i-1];
            assign y_in = r_y[i-1];
            assign z_in = r_z[i-1];
            assign q_in = r_q[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[i] <= q_in;
                if (!z_in[ZW-1]) begin
                    r_x[i] <= x_in - (y_in >>> i);
                    r_y[i] <= y_in + (x_in >>> i);
                    r_z[i] <= z_in - ARC_TABLE[i];
                end else begin
                    r_x[i] <= x_in + (y_in >>> i);
                    r_y[i] <= y_in - (x_in >>> i);
                    r_z[i] <= z_in + ARC_TABLE[i];
                end
            end
        end
    end

    always_comb begin
        case (r_q[CORDIC_STEPS-1])
            2'd0: begin
                o_unit.co = r_x[CORDIC_STEPS-1];
                o_unit.si = r_y[CORDIC_STEPS-1];
            end
            2'd1: begin
                o_unit.co = -r_y[CORDIC_STEPS-1];
                o_unit.si = r_x[CORDIC_STEPS-1];
            end
            2'd2: begin
                o_unit.co = -r_x[CORDIC_STEPS-1];
                o_unit.si = -r_y[CORDIC_STEPS-1];
            end
            default: begin
                o_unit.co = r_y[CORDIC_STEPS-1];
                o_unit.si = -r_x[CORDIC_STEPS-1];
            end
        endcase
    end

    logic unused_z;
    assign unused_z = ^r_z[CORDIC_STEPS-1];

endmodule

[rtl/core/tlkj_merge.sv]
// ----------------------------------------------------------------------------
// tlkj_merge
// Combine both lane vectors into pose, Jacobian and twist.
// ----------------------------------------------------------------------------
module tlkj_merge
    import tlkj_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_en,
    input  t_link_cfg i_cfg,
    input  t_unit     i_u1,
    input  t_unit     i_u12,
    input  t_side     i_side,
    output t_result   o_res
);

    localparam logic signed [49:0] ROUND_UNIT = 50'sd1 <<< (UNIT_SHIFT - 1);
    localparam logic signed [34:0] HALF       = 35'sd1 <<< (FRAC_BITS - 1);

    function automatic logic signed [TERM_W-1:0] scale_len(
        input logic [LEN_W-1:0]        len,
        input logic signed [UNIT_W-1:0] u
    );
        logic signed [49:0] p;
        p = $signed({1'b0, len}) * u;
        p = p + ROUND_UNIT;
        return p[UNIT_SHIFT+TERM_W-1:UNIT_SHIFT];
    endfunction

    t_side                     r1_side;
    logic signed [TERM_W-1:0]  r1_c1, r1_s1, r1_c12, r1_s12;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side <= i_side;
            r1_c1   <= scale_len(i_cfg.len_one, i_u1.co);
            r1_s1   <= scale_len(i_cfg.len_one, i_u1.si);
            r1_c12  <= scale_len(i_cfg.len_two, i_u12.co);
            r1_s12  <= scale_len(i_cfg.len_two, i_u12.si);
        end
    end

    logic signed [17:0] n2_px, n2_py;

    assign n2_px = sat18(20'(r1_c1) + 20'(r1_c12));
    assign n2_py = sat18(20'(r1_s1) + 20'(r1_s12));

    t_side              r2_side;
    logic signed [17:0] r2_px, r2_py, r2_jxq1;
    logic signed [16:0] r2_jxq2, r2_jyq2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_side <= r1_side;
            r2_px   <= n2_px;
            r2_py   <= n2_py;
            r2_jxq1 <= sat18(-20'(n2_py));
            r2_jxq2 <= sat17(-20'(r1_s12));
            r2_jyq2 <= sat17(20'(r1_c12));
        end
    end

    t_side              r3_side;
    logic signed [17:0] r3_px, r3_py, r3_jxq1;
    logic signed [16:0] r3_jxq2, r3_jyq2;
    logic signed [33:0] r3_xa, r3_xb, r3_ya, r3_yb;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_side <= r2_side;
            r3_px   <= r2_px;
            r3_py   <= r2_py;
            r3_jxq1 <= r2_jxq1;
            r3_jxq2 <= r2_jxq2;
            r3_jyq2 <= r2_jyq2;
            r3_xa   <= r2_jxq1 * r2_side.rate_one;
            r3_xb   <= 34'(r2_jxq2) * r2_side.rate_two;
            r3_ya   <= r2_px * r2_side.rate_one;
            r3_yb   <= 34'(r2_jyq2) * r2_side.rate_two;
        end
    end

    logic signed [34:0] sum_x, sum_y;

    assign sum_x = (35'(r3_xa) + 35'(r3_xb) + HALF) >>> FRAC_BITS;
    assign sum_y = (35'(r3_ya) + 35'(r3_yb) + HALF) >>> FRAC_BITS;

    always_comb begin
        o_res.pose_x   = r3_px;
        o_res.pose_y   = r3_py;
        o_res.pose_phi = r3_side.phi;
        o_res.jac_xq1  = r3_jxq1;
        o_res.jac_xq2  = r3_jxq2;
        o_res.jac_yq1  = r3_px;
        o_res.jac_yq2  = r3_jyq2;
        o_res.vel_x    = sat22(sum_x);
        o_res.vel_y    = sat22(sum_y);
        o_res.vel_w    = r3_side.vel_w;
    end

endmodule

[rtl/core/two_link_planar_kinematics_jacobian.sv]
// ----------------------------------------------------------------------------
// two_link_planar_kinematics_jacobian
// Pose, Jacobian and end twist of a planar two-link arm.
// ----------------------------------------------------------------------------
// One item per clock in steady state while the output is not stalled. From input
// accept to output valid, two 24-stage CORDIC lanes (first angle, angle sum) run
// side by side, then three merge stages and the output register. The whole
// pipeline advances whenever the output register is empty or being taken.
// ----------------------------------------------------------------------------
module two_link_planar_kinematics_jacobian
    import tlkj_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [LEN_W-1:0]      i_cfg_data,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // angle_one, angle_two, rate_one, rate_two
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // pose_x, pose_y, pose_phi, jac_xq1, jac_xq2, jac_yq1, jac_yq2,
    // vel_x, vel_y, vel_w, zero pad
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    localparam int PIPE_D = CORDIC_STEPS + 3;

    t_link_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.len_one <= LEN_RESET;
            r_cfg.len_two <= LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_LEN_ONE: r_cfg.len_one <= i_cfg_data;
                REG_LEN_TWO: r_cfg.len_two <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    logic accept;
    logic r_out_valid;

    assign en         = !r_out_valid || i_m_tready;
    assign o_s_tready = en;
    assign accept     = i_s_tvalid && en;

    logic [ANGLE_BITS-1:0] a1, a12;
    t_side                 side_in;

    assign a1  = i_s_tdata[15:0];
    assign a12 = a1 + i_s_tdata[31:16];

    always_comb begin
        side_in.phi      = a12;
        side_in.rate_one = i_s_tdata[47:32];
        side_in.rate_two = i_s_tdata[63:48];
        side_in.vel_w    = 17'(side_in.rate_one) + 17'(side_in.rate_two);
    end

    t_side r_side [CORDIC_STEPS];
    logic  r_vld  [PIPE_D];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= side_in;
            for (int i = 1; i < CORDIC_STEPS; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PIPE_D; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_s_tvalid;
            for (int i = 1; i < PIPE_D; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    t_unit u1, u12;

    tlkj_cordic_lane u_lane_one (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (a1),
        .o_unit  (u1)
    );

    tlkj_cordic_lane u_lane_sum (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (a12),
        .o_unit  (u12)
    );

    t_result res;

    tlkj_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_cfg  (r_cfg),
        .i_u1   (u1),
        .i_u12  (u12),
        .i_side (r_side[CORDIC_STEPS-1]),
        .o_res  (res)
    );

    t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_vld[PIPE_D-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out};

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not follow output stall");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_out.jac_yq1 == r_out.pose_x))
        else $error("jac_yq1 differs from pose_x");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_vld[0])
        else $error("accepted item lost at pipeline entry");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(r_out)))
        else $error("stalled result changed");

endmodule
